/* rtl/ufbd_pkg.sv */
package ufbd_pkg;

  localparam int FIFO_DEPTH_DEF = 128;
  localparam int BURST_MAX_DEF  = 4;

  // Burst bytes carried in one result, and fixed result field widths
  localparam int SHOWN_BYTES = 4;
  localparam int LEN_W       = 3;
  localparam int LEVEL_W     = 8;
  localparam int RES_W       = 1 + LEN_W + 8 * SHOWN_BYTES + LEVEL_W + 1;
  localparam int M_TDATA_W   = ((RES_W + 7) / 8) * 8;

  typedef enum logic {
    REQ_WRITE   = 1'b0,
    REQ_TX_DONE = 1'b1
  } req_t;

  // Packed lowest-first: accepted at bit 0, tx_busy on top
  typedef struct packed {
    logic                              tx_busy;
    logic [LEVEL_W-1:0]                fifo_level;
    logic [SHOWN_BYTES-1:0][7:0]       burst_bytes;
    logic [LEN_W-1:0]                  burst_len;
    logic                              accepted;
  } result_t;

endpackage

/* rtl/ufbd_mem.sv */
module ufbd_mem #(
  parameter int DEPTH = ufbd_pkg::FIFO_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

/* rtl/ufbd_ctrl.sv */
module ufbd_ctrl #(
  parameter int FIFO_DEPTH = ufbd_pkg::FIFO_DEPTH_DEF,
  parameter int BURST_MAX  = ufbd_pkg::BURST_MAX_DEF,
  parameter int AW         = $clog2(FIFO_DEPTH),
  parameter int CW         = $clog2(FIFO_DEPTH + 1),
  parameter int NW         = $clog2(BURST_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst,
  // item side
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [7:0]          data_byte,
  input  logic                first_of_call,
  input  logic                last_of_call,
  // result side
  output logic                res_valid,
  input  logic                res_ready,
  output ufbd_pkg::result_t   res,
  // byte store ports
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] read_pointer, write_pointer;
  logic [CW-1:0] fill_count;
  logic          busy_flag;
  logic          start_pending;
  logic          accepted;
  logic [NW-1:0] burst_n;
  logic [NW-1:0] issued;
  logic          rd_vld;
  logic [NW-1:0] rd_slot;
  logic [7:0]    shown [ufbd_pkg::SHOWN_BYTES];

  logic          take;
  logic          is_write;
  logic          room;
  logic          pend_eff;
  logic          want_burst;
  logic [CW-1:0] fill_wr;
  logic [NW-1:0] n_calc;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign is_write = (ufbd_pkg::req_t'(req_type) == ufbd_pkg::REQ_WRITE);
  assign room     = (fill_count != CW'(FIFO_DEPTH));
  assign pend_eff = first_of_call ? ((fill_count == '0) && !busy_flag) : start_pending;
  assign fill_wr  = fill_count + CW'(is_write && room);

  always_comb begin
    want_burst = is_write ? (last_of_call && pend_eff) : (fill_count != '0);
    n_calc     = '0;
    if (want_burst) begin
      if (32'(fill_wr) < BURST_MAX) begin
        n_calc = NW'(fill_wr);
      end else begin
        n_calc = NW'(BURST_MAX);
      end
    end
  end

  // Store write happens in the accept cycle; reads start in the cycle after it
  assign wr_en   = take && is_write && room;
  assign wr_addr = write_pointer;
  assign wr_data = data_byte;
  assign rd_en   = (state == S_READ);
  assign rd_addr = read_pointer;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          state_next = (n_calc != '0) ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        if (issued == burst_n - NW'(1)) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
      busy_flag     <= 1'b0;
      start_pending <= 1'b0;
      rd_vld        <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (take) begin
        fill_count <= fill_wr - CW'(n_calc);
        if (wr_en) begin
          write_pointer <= wrap_inc(write_pointer);
        end
        if (is_write) begin
          if (last_of_call) begin
            start_pending <= 1'b0;
          end else if (first_of_call) begin
            start_pending <= pend_eff;
          end
        end
        if (n_calc != '0) begin
          busy_flag <= 1'b1;
        end else if (!is_write && fill_count == '0) begin
          busy_flag <= 1'b0;
        end
      end
      if (rd_en) begin
        read_pointer <= wrap_inc(read_pointer);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted <= wr_en;
      burst_n  <= n_calc;
      issued   <= '0;
      for (int i = 0; i < ufbd_pkg::SHOWN_BYTES; i++) begin
        shown[i] <= 8'd0;
      end
    end else begin
      if (rd_en) begin
        issued <= issued + NW'(1);
      end
      if (rd_vld && 32'(rd_slot) < ufbd_pkg::SHOWN_BYTES) begin
        shown[2'(rd_slot)] <= rd_data;
      end
    end
    rd_slot <= issued;
  end

  assign res_valid = (state == S_DONE);

  always_comb begin
    res.accepted   = accepted;
    res.burst_len  = ufbd_pkg::LEN_W'(burst_n);
    res.fifo_level = ufbd_pkg::LEVEL_W'(fill_count);
    res.tx_busy    = busy_flag;
    for (int i = 0; i < ufbd_pkg::SHOWN_BYTES; i++) begin
      res.burst_bytes[i] = shown[i];
    end
  end

endmodule

/* rtl/uart_tx_fifo_burst_drain.sv */
// Channel | Dir | Fields (lowest bit first)                              | Accepted when
// --------+-----+--------------------------------------------------------+--------------------
// s_      | in  | tdata: data_byte; tuser: req_type, first_of_call;       | s_tvalid & s_tready
//         |     | tlast: last_of_call                                     |
// m_      | out | tdata: accepted, burst_len, burst_byte0..3, fifo_level,  | m_tvalid & m_tready
//         |     | tx_busy, zero pad                                       |
//
// One item at a time. An item with no burst goes from accept straight to
// result hand-off; an item that drains bytes reads them in turn on the single
// read port of the byte store and passes a flush state before hand-off.
// rst is synchronous; it clears pointers, fill count, busy and the pending
// start flag. The byte store itself is not cleared.
// A stalled m_ side holds the result in the output register; the next item
// is taken while it waits and stalls only at its own hand-off.
module uart_tx_fifo_burst_drain #(
  parameter int FIFO_DEPTH = ufbd_pkg::FIFO_DEPTH_DEF,
  parameter int BURST_MAX  = ufbd_pkg::BURST_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic [1:0]                     s_tuser,   // [0] req_type, [1] first_of_call
  input  logic                           s_tlast,   // last_of_call
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] accepted, [3:1] burst_len, [11:4] burst_byte0, [19:12] burst_byte1,
  // [27:20] burst_byte2, [35:28] burst_byte3, [43:36] fifo_level,
  // [44] tx_busy, [47:45] zero
  output logic [ufbd_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(FIFO_DEPTH);

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;
  logic              res_valid, res_ready;
  ufbd_pkg::result_t res;
  ufbd_pkg::result_t out_reg;

  ufbd_mem #(
    .DEPTH (FIFO_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ufbd_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .BURST_MAX  (BURST_MAX)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .req_type      (s_tuser[0]),
    .data_byte     (s_tdata),
    .first_of_call (s_tuser[1]),
    .last_of_call  (s_tlast),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data)
  );

  // Output register: load when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_reg <= res;
    end
  end

  assign m_tdata = ufbd_pkg::M_TDATA_W'(out_reg);

endmodule

/* rtl/ufbd_checker.sv */
module ufbd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ufbd_pkg::M_TDATA_W-1:0] m_tdata
);

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken back to back");

  // No burst means all burst bytes are zero
  a_empty_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:1] == 3'd0 |-> m_tdata[35:4] == 32'd0)
    else $error("burst bytes set without a burst");

  // Any burst leaves the transmitter busy
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:1] != 3'd0 |-> m_tdata[44])
    else $error("burst sent with busy clear");

endmodule

bind uart_tx_fifo_burst_drain ufbd_checker u_ufbd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* sim/uart_tx_burst_checker.sv */
`timescale 1ns / 1ps

module uart_tx_burst_checker #(
  parameter int FIFO_DEPTH = ufbd_pkg::FIFO_DEPTH_DEF,
  parameter int BURST_MAX  = ufbd_pkg::BURST_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic [1:0]                     s_tuser,   // [0] req_type, [1] first_of_call
  input  logic                           s_tlast,   // last_of_call
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // accepted, burst_len, burst_byte0..3, fifo_level, tx_busy, zero pad
  input  logic [ufbd_pkg::M_TDATA_W-1:0] m_tdata,
  output int                             errors,
  output int                             outstanding,
  output int                             writes_seen,
  output int                             drops_seen,
  output int                             bursts_seen,
  output int                             peak_level
);

  localparam int LW = ufbd_pkg::LEVEL_W;
  localparam int NW = ufbd_pkg::LEN_W;

  // Shadow copy of the FIFO and transmitter flags
  logic [7:0]  shadow_store [FIFO_DEPTH];
  int unsigned rd_idx = 0;
  int unsigned wr_idx = 0;
  int unsigned level = 0;
  bit          busy = 1'b0;
  bit          start_armed = 1'b0;

  ufbd_pkg::result_t tx_results_q[$];

  int err_count = 0;
  int owed_r = 0;
  int n_writes = 0;
  int n_drops = 0;
  int n_bursts = 0;
  int n_peak = 0;

  assign errors      = err_count;
  assign outstanding = owed_r;
  assign writes_seen = n_writes;
  assign drops_seen  = n_drops;
  assign bursts_seen = n_bursts;
  assign peak_level  = n_peak;

  // Pull up to BURST_MAX oldest bytes out of the shadow FIFO
  function automatic void drain_burst(inout ufbd_pkg::result_t r);
    int unsigned n;
    n = (level < BURST_MAX) ? level : BURST_MAX;
    for (int unsigned k = 0; k < n; k++) begin
      if (k < ufbd_pkg::SHOWN_BYTES) r.burst_bytes[k] = shadow_store[rd_idx];
      rd_idx = (rd_idx + 1) % FIFO_DEPTH;
      level--;
      busy = 1'b1;
    end
    r.burst_len = NW'(n);
  endfunction

  function automatic ufbd_pkg::result_t fifo_step(ufbd_pkg::req_t req, logic [7:0] data,
                                                  logic first, logic last);
    ufbd_pkg::result_t r;
    r = '0;
    if (req == ufbd_pkg::REQ_WRITE) begin
      if (first) start_armed = (level == 0) && !busy;
      if (level < FIFO_DEPTH) begin
        shadow_store[wr_idx] = data;
        wr_idx = (wr_idx + 1) % FIFO_DEPTH;
        level++;
        r.accepted = 1'b1;
      end
      if (last) begin
        if (start_armed) drain_burst(r);
        start_armed = 1'b0;
      end
    end else if (level == 0) begin
      busy = 1'b0;
    end else begin
      drain_burst(r);
    end
    r.fifo_level = LW'(level);
    r.tx_busy    = busy;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    ufbd_pkg::result_t want;
    ufbd_pkg::result_t got;
    ufbd_pkg::req_t    req;
    if (rst) begin
      rd_idx = 0;
      wr_idx = 0;
      level = 0;
      busy = 1'b0;
      start_armed = 1'b0;
      tx_results_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        req  = ufbd_pkg::req_t'(s_tuser[0]);
        want = fifo_step(req, s_tdata, s_tuser[1], s_tlast);
        tx_results_q.push_back(want);
        if (req == ufbd_pkg::REQ_WRITE) begin
          n_writes++;
          if (!want.accepted) n_drops++;
        end
        if (want.burst_len != 0) n_bursts++;
        if (level > n_peak) n_peak = level;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[ufbd_pkg::RES_W-1:0];
        if (tx_results_q.size() == 0) begin
          $error("result with no transaction pending: %h", m_tdata);
          err_count++;
        end else begin
          want = tx_results_q.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("burst_len", want.burst_len, got.burst_len);
          for (int k = 0; k < ufbd_pkg::SHOWN_BYTES; k++)
            check_field($sformatf("burst_byte%0d", k), want.burst_bytes[k],
                        got.burst_bytes[k]);
          check_field("fifo_level", want.fifo_level, got.fifo_level);
          check_field("tx_busy", want.tx_busy, got.tx_busy);
        end
      end
    end
    owed_r <= tx_results_q.size();
  end

endmodule

/* sim/uart_tx_fifo_burst_drain_tb.sv */
`timescale 1ns / 1ps

module uart_tx_fifo_burst_drain_tb;

  localparam int RANDOM_ITEMS = 1400;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata = '0;    // [7:0] data_byte
  logic [1:0]                     s_tuser = '0;    // [0] req_type, [1] first_of_call
  logic                           s_tlast = 1'b0;  // last_of_call
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // accepted, burst_len, burst_byte0..3, fifo_level, tx_busy, zero pad
  logic [ufbd_pkg::M_TDATA_W-1:0] m_tdata;

  int errors, outstanding, writes_seen, drops_seen, bursts_seen, peak_level;
  int sent_items = 0;

  // Set during stretches that run both sides at full rate
  bit steady = 1'b0;

  always #1 clk = ~clk;

  uart_tx_fifo_burst_drain u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  uart_tx_burst_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding),
    .writes_seen (writes_seen),
    .drops_seen  (drops_seen),
    .bursts_seen (bursts_seen),
    .peak_level  (peak_level)
  );

  // Hold reset from time zero, then release it once
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Gap length: mostly none or short, now and then long; none in steady stretches
  function automatic int idle_len();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and hold it until the transaction completes. Drop valid
  // only when a gap follows, so valid never gets two updates in one step.
  task automatic put_item(ufbd_pkg::req_t req, logic [7:0] data, logic first, logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {first, req};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  // Transmit-done events; the data and call marks are ignored, so randomize them
  task automatic put_events(int n);
    for (int i = 0; i < n; i++)
      put_item(ufbd_pkg::REQ_TX_DONE, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // One write call of random bytes; optionally drop either mark or slip an
  // event in after the first byte, before a later one (skipped if the cut is len)
  task automatic put_call(int len, bit mark_first, bit mark_last, bit event_inside);
    int cut;
    cut = $urandom_range(1, len);
    for (int i = 0; i < len; i++) begin
      if (event_inside && i == cut) put_events(1);
      put_item(ufbd_pkg::REQ_WRITE, 8'($urandom), mark_first && i == 0,
               mark_last && i == len - 1);
    end
  endtask

  // Sink side: runs of ready broken by stalls of random length
  initial begin
    while (rst) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      begin
        int stall;
        stall = idle_len();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int  roll;
    bit  flooded;
    flooded = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed: event on an idle empty FIFO with every ignored bit set
    put_item(ufbd_pkg::REQ_TX_DONE, 8'hFF, 1'b1, 1'b1);
    // Single-byte call starts a one-byte burst, then the event clears busy
    put_item(ufbd_pkg::REQ_WRITE, 8'h00, 1'b1, 1'b1);
    put_item(ufbd_pkg::REQ_TX_DONE, 8'h00, 1'b0, 1'b0);
    // Six-byte call: full burst of four, then a short burst of two
    put_item(ufbd_pkg::REQ_WRITE, 8'hFF, 1'b1, 1'b0);
    put_item(ufbd_pkg::REQ_WRITE, 8'h01, 1'b0, 1'b0);
    put_item(ufbd_pkg::REQ_WRITE, 8'h80, 1'b0, 1'b0);
    put_item(ufbd_pkg::REQ_WRITE, 8'hAA, 1'b0, 1'b0);
    put_item(ufbd_pkg::REQ_WRITE, 8'h55, 1'b0, 1'b0);
    put_item(ufbd_pkg::REQ_WRITE, 8'h7E, 1'b0, 1'b1);
    put_events(2);
    // Event inside a call drains the first byte; the start decision still holds
    put_item(ufbd_pkg::REQ_WRITE, 8'hA5, 1'b1, 1'b0);
    put_item(ufbd_pkg::REQ_TX_DONE, 8'h00, 1'b0, 1'b0);
    put_item(ufbd_pkg::REQ_WRITE, 8'h5A, 1'b0, 1'b1);
    put_events(1);
    // Last mark with no first mark: the cleared start decision sends nothing
    put_item(ufbd_pkg::REQ_WRITE, 8'h3C, 1'b0, 1'b1);
    // Call opened on a non-empty FIFO does not start a burst
    put_item(ufbd_pkg::REQ_WRITE, 8'hC3, 1'b1, 1'b0);
    put_item(ufbd_pkg::REQ_WRITE, 8'h99, 1'b0, 1'b0);
    put_item(ufbd_pkg::REQ_WRITE, 8'h66, 1'b0, 1'b1);
    put_events(2);

    // Random: mostly well-formed calls with drain events, plus events alone,
    // broken calls, raw noise and the odd flood that overruns the FIFO
    while (sent_items < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if ((!flooded && sent_items > 600) || roll == 0) begin
        flooded = 1'b1;
        put_call(ufbd_pkg::FIFO_DEPTH_DEF + $urandom_range(4, 12), 1'b1, 1'b1, 1'b0);
        put_events(ufbd_pkg::FIFO_DEPTH_DEF / ufbd_pkg::BURST_MAX_DEF + 2);
      end else if (roll < 70) begin
        put_call(($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8),
                 1'b1, 1'b1, $urandom_range(0, 9) == 0);
        put_events($urandom_range(0, 3));
      end else if (roll < 85) begin
        put_events($urandom_range(1, 4));
      end else if (roll < 95) begin
        put_call($urandom_range(1, 6), 1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          put_item(ufbd_pkg::req_t'($urandom_range(0, 1)), 8'($urandom),
                   1'($urandom), 1'($urandom));
      end
    end

    // Stop offering, let every expected result come back, then settle
    s_tvalid <= 1'b0;
    steady = 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);

    $display("covered %0d transactions: %0d writes, %0d dropped at full FIFO",
             sent_items, writes_seen, drops_seen);
    $display("bursts sent: %0d, peak FIFO level: %0d", bursts_seen, peak_level);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* uart_tx_fifo_burst_drain.f */
rtl/ufbd_pkg.sv
rtl/ufbd_mem.sv
rtl/ufbd_ctrl.sv
rtl/uart_tx_fifo_burst_drain.sv
rtl/ufbd_checker.sv
sim/uart_tx_burst_checker.sv
sim/uart_tx_fifo_burst_drain_tb.sv
